FILE: rtl/core/kpd_pkg.sv
// kpd_pkg: shared types, constants and helpers of the keypad matrix change detector
// no dependencies; compiled first

package kpd_pkg;

  localparam int MAP_W       = 64;  // one bit per key
  localparam int CODE_W      = 6;   // scan code width
  localparam int DIM_W       = 4;   // rows / cols register width
  localparam int POS_W       = 3;   // row or column position
  localparam int SHIFT_W     = 2;   // scan code row shift, 0..3
  localparam int IDX_W       = 6;   // key index, 0..63
  localparam int HOLD_W      = 16;
  localparam int PAIR_W      = 32;
  localparam int HALF_W      = 16;
  localparam int ACT_W       = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // saturating count of pressed keys
  localparam logic [1:0] PRESS_NONE  = 2'd0;
  localparam logic [1:0] PRESS_ONE   = 2'd1;
  localparam logic [1:0] PRESS_PAIR  = 2'd2;
  localparam logic [1:0] PRESS_GHOST = 2'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUM_ROWS,
    REG_NUM_COLS,
    REG_PAIR_A,
    REG_PAIR_B,
    REG_HOLD
  } reg_index_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_LEAVE,
    ACT_DRIVE,
    ACT_PULSE
  } action_t;

  typedef struct packed {
    logic [MAP_W-1:0] pressed_map;
  } snapshot_t;

  typedef struct packed {
    logic              event_valid;
    logic [CODE_W-1:0] scan_code;
    logic              key_down;
    logic              last_of_scan;
    logic [MAP_W-1:0]  key_map;
    logic              ghost_rejected;
    logic [ACT_W-1:0]  enable_action;
  } result_t;

  // effective matrix geometry
  typedef struct packed {
    logic [POS_W-1:0]   rows_m1;
    logic [SHIFT_W-1:0] shift;
    logic [IDX_W-1:0]   keys_m1;
  } geom_t;

  // outcome of the counting pass
  typedef struct packed {
    logic [1:0]        pressed;
    logic [CODE_W-1:0] code_a;
    logic [CODE_W-1:0] code_b;
  } count_res_t;

  // per-scan fields carried on every result
  typedef struct packed {
    logic    ghost;
    action_t action;
  } scan_flags_t;

  // column always fits below the row shift, so or-ing is the same as adding
  function automatic logic [CODE_W-1:0] code_of(logic [POS_W-1:0] row,
                                                logic [POS_W-1:0] col,
                                                logic [SHIFT_W-1:0] shift);
    return (CODE_W'(row) << shift) | CODE_W'(col);
  endfunction

endpackage

FILE: rtl/core/kpd_stream_if.sv
// kpd_stream_if: valid/ready channel carrying one word of a given payload type
// no dependencies; payload types come from kpd_pkg at the instantiation

interface kpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/kpd_scan_count.sv
// kpd_scan_count: bit-serial pass over a masked snapshot, one key per cycle
// counts pressed keys (saturating) and captures the first two scan codes
// depends on kpd_pkg

module kpd_scan_count (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  kpd_pkg::geom_t            geom,
  input  logic [kpd_pkg::MAP_W-1:0] snap,
  output logic                      done,
  output kpd_pkg::count_res_t       res
);
  import kpd_pkg::*;

  logic [MAP_W-1:0]  sr;
  logic [IDX_W-1:0]  idx;
  logic [POS_W-1:0]  row;
  logic [POS_W-1:0]  col;
  logic              running;
  logic [CODE_W-1:0] code;

  assign code = code_of(row, col, geom.shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      // pulse after the last key of the matrix went through
      done <= !start && running && (idx == geom.keys_m1);
      if (start) begin
        sr          <= snap;
        idx         <= '0;
        row         <= '0;
        col         <= '0;
        res.pressed <= PRESS_NONE;
        running     <= 1'b1;
      end else if (running) begin
        sr <= sr >> 1;
        if (sr[0]) begin
          if (res.pressed == PRESS_NONE) res.code_a <= code;
          if (res.pressed == PRESS_ONE) res.code_b <= code;
          if (res.pressed != PRESS_GHOST) res.pressed <= res.pressed + 1'b1;
        end
        // column-major walk
        if (row == geom.rows_m1) begin
          row <= '0;
          col <= col + 1'b1;
        end else begin
          row <= row + 1'b1;
        end
        idx <= idx + 1'b1;
        if (idx == geom.keys_m1) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/kpd_change_walk.sv
// kpd_change_walk: bit-serial walk over the changed-key map, one key per cycle unless a changed key
// waits for a free output slot; one word per changed key (one empty word if none) goes to the output register
// depends on kpd_pkg and kpd_stream_if

module kpd_change_walk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  kpd_pkg::geom_t            geom,
  input  logic [kpd_pkg::MAP_W-1:0] changed,
  input  logic [kpd_pkg::MAP_W-1:0] key_map,
  input  kpd_pkg::scan_flags_t      flags,
  output logic                      busy,
  kpd_stream_if.source              key_events
);
  import kpd_pkg::*;

  typedef enum logic [1:0] {
    W_IDLE,
    W_EMPTY,
    W_RUN
  } wstate_t;

  wstate_t          state;
  logic [MAP_W-1:0] chg_sr;
  logic [MAP_W-1:0] new_sr;
  logic [MAP_W-1:0] map;
  scan_flags_t      flags_r;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic             slot_free;
  logic             rest_zero;
  logic             emit;
  result_t          word;

  assign busy      = (state != W_IDLE);
  assign slot_free = !key_events.valid || key_events.ready;
  assign rest_zero = (chg_sr[MAP_W-1:1] == '0);
  // a word goes into the output register this cycle
  assign emit      = slot_free && ((state == W_EMPTY) || (state == W_RUN && chg_sr[0]));

  always_comb begin
    word.event_valid    = (state == W_RUN);
    word.scan_code      = (state == W_RUN) ? code_of(row, col, geom.shift) : '0;
    word.key_down       = (state == W_RUN) && new_sr[0];
    word.last_of_scan   = (state == W_EMPTY) || rest_zero;
    word.key_map        = map;
    word.ghost_rejected = flags_r.ghost;
    word.enable_action  = flags_r.action;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= W_IDLE;
      key_events.valid <= 1'b0;
    end else begin
      if (emit) key_events.valid <= 1'b1;
      else if (key_events.ready) key_events.valid <= 1'b0;
      unique case (state)
        W_IDLE: begin
          if (load) begin
            chg_sr  <= changed;
            new_sr  <= key_map;
            map     <= key_map;
            flags_r <= flags;
            row     <= '0;
            col     <= '0;
            state   <= (changed == '0) ? W_EMPTY : W_RUN;
          end
        end
        W_EMPTY: begin
          if (slot_free) begin
            key_events.payload <= word;
            state              <= W_IDLE;
          end
        end
        W_RUN: begin
          // a changed key waits for a free output slot, others pass at once
          if (!chg_sr[0] || slot_free) begin
            chg_sr <= chg_sr >> 1;
            new_sr <= new_sr >> 1;
            if (row == geom.rows_m1) begin
              row <= '0;
              col <= col + 1'b1;
            end else begin
              row <= row + 1'b1;
            end
            if (chg_sr[0]) begin
              key_events.payload <= word;
              if (rest_zero) state <= W_IDLE;
            end
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/keypad_matrix_change_detector.sv
// keypad_matrix_change_detector: top level, config registers, scan sequencer,
// ghost rejection and two-key shutdown hold counter
// depends on kpd_pkg, kpd_stream_if, kpd_scan_count, kpd_change_walk
//
//   channel     | role | handshake       | word
//   ------------+------+-----------------+----------------------------------------
//   snapshot    | sink | valid/ready     | pressed_map
//   key_events  | src  | valid/ready     | event_valid, scan_code, key_down,
//               |      |                 | last_of_scan, key_map, ghost_rejected,
//               |      |                 | enable_action
//   cfg         | sink | cfg_we strobe   | cfg_index, cfg_data
//
// one snapshot at a time: the counting pass over all keys, the shutdown counter
//   step, then the walk up to the last changed key
// both passes move one key bit per cycle through a shift register; output stalls
//   hold the walk on the changed key that waits; the next snapshot is taken
//   while the final word still sits in the output register
// reset is synchronous and clears the key map and the hold counter; the config
//   registers go to 8 rows, 8 cols and zero pairs and hold

module keypad_matrix_change_detector #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  kpd_stream_if.sink                      snapshot,
  kpd_stream_if.source                    key_events,
  input  logic                            cfg_we,
  input  logic [kpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kpd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,
    S_HOLD,
    S_WALK
  } state_t;

  // configuration registers
  logic [DIM_W-1:0]  num_rows;
  logic [DIM_W-1:0]  num_cols;
  logic [PAIR_W-1:0] shutdown_pair_a;
  logic [PAIR_W-1:0] shutdown_pair_b;
  logic [HOLD_W-1:0] shutdown_hold;

  // scan state
  state_t            state;
  logic [MAP_W-1:0]  accepted_map;
  logic [HOLD_W-1:0] hold_count;
  logic [HOLD_W-1:0] hold_count_next;
  logic [MAP_W-1:0]  snap;
  logic [MAP_W-1:0]  changed;
  logic              ghost;
  logic              chk;
  logic              match;

  // geometry
  logic [DIM_W-1:0]   rows_eff;
  logic [DIM_W-1:0]   cols_eff;
  logic [DIM_W-1:0]   rows_eff_m1;
  logic [2*DIM_W-1:0] keys;
  logic [2*DIM_W-1:0] keys_m1;
  logic [MAP_W-1:0]   area;
  geom_t              geom;

  // counting pass and decision
  logic              accept;
  logic              cnt_done;
  count_res_t        cnt_res;
  logic              ghost_c;
  logic [MAP_W-1:0]  newmap_c;
  logic [CODE_W-1:0] code_lo;
  logic [CODE_W-1:0] code_hi;
  logic [PAIR_W-1:0] pair_c;
  logic              chk_c;
  logic              match_c;
  action_t           action_c;
  logic              walk_load;
  logic              walk_busy;
  scan_flags_t       flags;

  // put a pair in order, lower half-word low
  function automatic logic [PAIR_W-1:0] order_pair(logic [PAIR_W-1:0] p);
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    lo = p[HALF_W-1:0];
    hi = p[PAIR_W-1:HALF_W];
    return (lo > hi) ? {lo, hi} : p;
  endfunction

  // ---------------------------------------------------------------------
  // configuration port, writes beyond the register list are dropped
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows        <= DIM_W'(8);
      num_cols        <= DIM_W'(8);
      shutdown_pair_a <= '0;
      shutdown_pair_b <= '0;
      shutdown_hold   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_ROWS: num_rows        <= cfg_data[DIM_W-1:0];
        REG_NUM_COLS: num_cols        <= cfg_data[DIM_W-1:0];
        REG_PAIR_A:   shutdown_pair_a <= cfg_data[PAIR_W-1:0];
        REG_PAIR_B:   shutdown_pair_b <= cfg_data[PAIR_W-1:0];
        REG_HOLD:     shutdown_hold   <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // effective geometry: zero acts as one, oversize clamps to the maximum
  // ---------------------------------------------------------------------
  always_comb begin
    if (num_rows == '0) rows_eff = DIM_W'(1);
    else if (num_rows > DIM_W'(MAX_ROWS)) rows_eff = DIM_W'(MAX_ROWS);
    else rows_eff = num_rows;

    if (num_cols == '0) cols_eff = DIM_W'(1);
    else if (num_cols > DIM_W'(MAX_COLS)) cols_eff = DIM_W'(MAX_COLS);
    else cols_eff = num_cols;

    rows_eff_m1  = rows_eff - 1'b1;
    keys         = rows_eff * cols_eff;
    keys_m1      = keys - 1'b1;
    geom.rows_m1 = rows_eff_m1[POS_W-1:0];
    geom.keys_m1 = keys_m1[IDX_W-1:0];

    // row shift is ceil(log2(cols))
    if (cols_eff > DIM_W'(4)) geom.shift = SHIFT_W'(3);
    else if (cols_eff > DIM_W'(2)) geom.shift = SHIFT_W'(2);
    else if (cols_eff > DIM_W'(1)) geom.shift = SHIFT_W'(1);
    else geom.shift = SHIFT_W'(0);

    // keys below rows*cols; a full 64-key matrix wraps to all ones
    area = (MAP_W'(2) << geom.keys_m1) - MAP_W'(1);
  end

  assign accept         = snapshot.valid && snapshot.ready;
  assign snapshot.ready = (state == S_IDLE);

  kpd_scan_count u_count (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .geom  (geom),
    .snap  (snapshot.payload.pressed_map & area),
    .done  (cnt_done),
    .res   (cnt_res)
  );

  // ---------------------------------------------------------------------
  // decision at the end of the counting pass
  // ---------------------------------------------------------------------
  always_comb begin
    ghost_c  = (cnt_res.pressed == PRESS_GHOST);
    newmap_c = ghost_c ? '0 : snap;
    if (cnt_res.code_a > cnt_res.code_b) begin
      code_lo = cnt_res.code_b;
      code_hi = cnt_res.code_a;
    end else begin
      code_lo = cnt_res.code_a;
      code_hi = cnt_res.code_b;
    end
    pair_c  = {HALF_W'(code_hi), HALF_W'(code_lo)};
    chk_c   = (cnt_res.pressed == PRESS_PAIR) &&
              (shutdown_pair_a != '0 || shutdown_pair_b != '0) &&
              (shutdown_hold != '0);
    match_c = (shutdown_pair_a != '0 && order_pair(shutdown_pair_a) == pair_c) ||
              (shutdown_pair_b != '0 && order_pair(shutdown_pair_b) == pair_c);
  end

  // hold counter saturates, and any other pair clears it
  always_comb begin
    if (!match) hold_count_next = '0;
    else if (hold_count == '1) hold_count_next = hold_count;
    else hold_count_next = hold_count + 1'b1;

    if (!chk) action_c = ACT_LEAVE;
    else if (hold_count_next >= shutdown_hold) action_c = ACT_PULSE;
    else action_c = ACT_DRIVE;
  end

  assign walk_load    = (state == S_HOLD);
  assign flags.ghost  = ghost;
  assign flags.action = action_c;

  // ---------------------------------------------------------------------
  // scan sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      accepted_map <= '0;
      hold_count   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            snap  <= snapshot.payload.pressed_map & area;
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (cnt_done) begin
            // stale bits outside the matrix drop out without an event
            changed      <= (accepted_map ^ newmap_c) & area;
            accepted_map <= newmap_c;
            ghost        <= ghost_c;
            chk          <= chk_c;
            match        <= match_c;
            state        <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (chk) hold_count <= hold_count_next;
          state <= S_WALK;
        end
        S_WALK: begin
          if (!walk_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  kpd_change_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .load       (walk_load),
    .geom       (geom),
    .changed    (changed),
    .key_map    (accepted_map),
    .flags      (flags),
    .busy       (walk_busy),
    .key_events (key_events)
  );

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_hold_only_in_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_HOLD |=> $stable(hold_count))
    else $error("hold counter moved outside the hold step");

  a_map_inside_matrix: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD |-> (accepted_map & ~area) == '0)
    else $error("accepted map holds keys outside the matrix");

  a_ghost_clears_map: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD && ghost |-> accepted_map == '0)
    else $error("ghost scan left keys in the map");

  a_walk_load_idle: assert property (@(posedge clk) disable iff (rst)
    walk_load |-> !walk_busy)
    else $error("walk loaded while still busy");

  a_count_done_in_count: assert property (@(posedge clk) disable iff (rst)
    cnt_done |-> state == S_COUNT)
    else $error("counting pass finished outside the count step");

endmodule
